@@ src/rmss_pkg.sv @@
// shared types and constants of the randomised music start scheduler
`default_nettype none

package rmss_pkg;

    // situation codes
    localparam logic [2:0] SIT_NONE       = 3'd0;
    localparam logic [2:0] SIT_MENU       = 3'd1;
    localparam logic [2:0] SIT_CREATIVE   = 3'd2;
    localparam logic [2:0] SIT_GAME       = 3'd3;
    localparam logic [2:0] SIT_UNDERWATER = 3'd4;

    // result action codes
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_W    = 3;
    localparam int         REG_IDX_W      = 2;
    localparam logic [2:0] REG_MENU       = 3'd0;
    localparam logic [2:0] REG_CREATIVE   = 3'd1;
    localparam logic [2:0] REG_GAME       = 3'd2;
    localparam logic [2:0] REG_UNDERWATER = 3'd3;
    localparam logic [2:0] REG_COUNT      = 3'd4;

    // track register layout
    localparam int TRACK_W    = 34;
    localparam int FIELD_W    = 16;
    localparam int MAX_LSB    = 16;
    localparam int REPL_BIT   = 32;
    localparam int MUSIC_BIT  = 33;

    localparam logic [TRACK_W-1:0] RST_MENU       = 34'd13671334288;
    localparam logic [TRACK_W-1:0] RST_CREATIVE   = 34'd14457777888;
    localparam logic [TRACK_W-1:0] RST_GAME       = 34'd10162810592;
    localparam logic [TRACK_W-1:0] RST_UNDERWATER = 34'd14457777888;

    // random generator and countdown constants
    localparam logic [31:0]        LCG_MUL     = 32'd1664525;
    localparam logic [31:0]        LCG_ADD     = 32'd1013904223;
    localparam int                 DRAW_SHIFT  = 8;
    localparam int                 DIVIDEND_W  = 32 - DRAW_SHIFT;
    localparam logic signed [31:0] COUNT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FLOOR_DELAY = 32'sd100;

    // request into the shared draw unit
    typedef struct packed {
        logic               start;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
    } t_draw_req;

    // answer from the shared draw unit
    typedef struct packed {
        logic               done;
        logic [FIELD_W-1:0] value;
    } t_draw_rsp;

endpackage

`default_nettype wire

@@ src/rmss_track_regs.sv @@
// track configuration registers and per-situation track selection
`default_nettype none

module rmss_track_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [rmss_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [rmss_pkg::TRACK_W-1:0]        i_cfg_data,
    input  wire logic [2:0]                          i_sel,
    output logic      [rmss_pkg::TRACK_W-1:0]        o_track
);

    logic [rmss_pkg::TRACK_W-1:0] r_track [4];

    // register writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track[rmss_pkg::REG_MENU[1:0]]       <= rmss_pkg::RST_MENU;
            r_track[rmss_pkg::REG_CREATIVE[1:0]]   <= rmss_pkg::RST_CREATIVE;
            r_track[rmss_pkg::REG_GAME[1:0]]       <= rmss_pkg::RST_GAME;
            r_track[rmss_pkg::REG_UNDERWATER[1:0]] <= rmss_pkg::RST_UNDERWATER;
        end else if (i_cfg_valid && (i_cfg_index < rmss_pkg::REG_COUNT)) begin
            r_track[i_cfg_index[rmss_pkg::REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // situations without a register read as silent
    always_comb begin
        unique case (i_sel)
            rmss_pkg::SIT_MENU:       o_track = r_track[rmss_pkg::REG_MENU[1:0]];
            rmss_pkg::SIT_CREATIVE:   o_track = r_track[rmss_pkg::REG_CREATIVE[1:0]];
            rmss_pkg::SIT_GAME:       o_track = r_track[rmss_pkg::REG_GAME[1:0]];
            rmss_pkg::SIT_UNDERWATER: o_track = r_track[rmss_pkg::REG_UNDERWATER[1:0]];
            default:                  o_track = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/rmss_draw.sv @@
// random delay draw: lcg step then bit-serial remainder by the delay span
`default_nettype none

module rmss_draw (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rmss_pkg::t_draw_req   i_req,
    output rmss_pkg::t_draw_rsp        o_rsp
);

    localparam int SPAN_W = rmss_pkg::FIELD_W + 1;
    localparam int CNT_W  = $clog2(rmss_pkg::DIVIDEND_W);

    typedef enum logic [1:0] {D_IDLE, D_LCG, D_DIV, D_DONE} t_dstate;

    t_dstate                            r_state;
    logic [31:0]                        r_lcg;
    logic [rmss_pkg::DIVIDEND_W-1:0]    r_div;
    logic [SPAN_W-1:0]                  r_span;
    logic [SPAN_W-1:0]                  r_rem;
    logic [rmss_pkg::FIELD_W-1:0]       r_lo;
    logic [CNT_W-1:0]                   r_cnt;

    logic [31:0]                        w_lcg_next;
    logic [SPAN_W:0]                    w_trial;
    logic [SPAN_W-1:0]                  w_rem_next;

    // next generator value
    assign w_lcg_next = 32'(r_lcg * rmss_pkg::LCG_MUL) + rmss_pkg::LCG_ADD;

    // one restoring remainder step
    assign w_trial    = {r_rem, r_div[rmss_pkg::DIVIDEND_W-1]};
    assign w_rem_next = (w_trial >= {1'b0, r_span}) ? SPAN_W'(w_trial - {1'b0, r_span})
                                                    : SPAN_W'(w_trial);

    // sequencer, generator and divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_lcg   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_lo <= i_req.lo;
                        if (i_req.hi <= i_req.lo) begin
                            r_rem   <= '0;
                            r_state <= D_DONE;
                        end else begin
                            r_span  <= SPAN_W'(i_req.hi - i_req.lo) + SPAN_W'(1);
                            r_state <= D_LCG;
                        end
                    end
                end
                D_LCG: begin
                    r_lcg   <= w_lcg_next;
                    r_div   <= w_lcg_next[31:rmss_pkg::DRAW_SHIFT];
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(rmss_pkg::DIVIDEND_W - 1);
                    r_state <= D_DIV;
                end
                D_DIV: begin
                    r_rem <= w_rem_next;
                    r_div <= {r_div[rmss_pkg::DIVIDEND_W-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= D_DONE;
                    end
                end
                D_DONE: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    // remainder stays below a non-empty span, so the sum never passes the max
    assign o_rsp.done  = (r_state == D_DONE);
    assign o_rsp.value = r_lo + r_rem[rmss_pkg::FIELD_W-1:0];

endmodule

`default_nettype wire

@@ src/randomized_music_start_scheduler_top.sv @@
// top level of the randomised music start scheduler
//
// One input transaction is one tick: the current situation and whether music
// is still sounding. Every tick gives exactly one result transaction: an
// action (nothing, start, replace) and the situation whose track to play.
// Four 34-bit track registers, one per playable situation (min delay, max
// delay, replace, has music fields), are written over the configuration
// channel, which is always ready; an index past the last register is
// ignored. Write them only while the block is idle. The draw unit advances
// the generator once and then forms the remainder one dividend bit per cycle
// over all 24 dividend bits; a draw over an empty span skips both steps. One
// tick is in work at a time and o_ready is high only while the sequencer is
// idle, so a new tick can be taken while the last result is shown.
// Reset clears the playing situation, sets the countdown to its maximum, the
// generator to zero and the track registers to their defaults.
// A result waits in the output register while i_ready is low; the next tick
// can still be accepted and worked on, and it holds in its last state until
// the output register is free.
`default_nettype none

module randomized_music_start_scheduler_top #(
    parameter int DELAY_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // tick channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [2:0]                        i_situation,
    input  wire logic                              i_music_sounding,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [1:0]                        o_action,
    output logic      [2:0]                        o_track_situation,
    // configuration channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rmss_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [rmss_pkg::TRACK_W-1:0]      i_cfg_data
);

    localparam int DW_EFF = (DELAY_WIDTH < rmss_pkg::FIELD_W) ? DELAY_WIDTH
                                                              : rmss_pkg::FIELD_W;
    localparam logic [rmss_pkg::FIELD_W-1:0] DELAY_MASK =
        rmss_pkg::FIELD_W'((33'd1 << DW_EFF) - 33'd1);

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_STEP, S_WAIT, S_OUT} t_state;

    t_state                          r_state,     n_state;
    logic [2:0]                      r_sit,       n_sit;
    logic                            r_sounding,  n_sounding;
    logic [rmss_pkg::TRACK_W-1:0]    r_cur,       n_cur;
    logic [2:0]                      r_playing,   n_playing;
    logic signed [31:0]              r_count,     n_count;
    logic                            r_reroll,    n_reroll;
    rmss_pkg::t_draw_req             r_draw_req,  n_draw_req;
    logic [1:0]                      r_res_act,   n_res_act;
    logic [2:0]                      r_res_sit,   n_res_sit;
    logic                            r_o_valid,   n_o_valid;
    logic [1:0]                      r_o_action,  n_o_action;
    logic [2:0]                      r_o_sit,     n_o_sit;

    logic [rmss_pkg::TRACK_W-1:0]    w_sel_track;
    rmss_pkg::t_draw_rsp             w_rsp;
    logic [rmss_pkg::FIELD_W-1:0]    w_lo;
    logic [rmss_pkg::FIELD_W-1:0]    w_hi;
    logic                            w_music;
    logic                            w_replace;
    logic signed [31:0]              w_d;
    logic signed [31:0]              w_newc;

    // track registers
    rmss_track_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sel       (i_situation),
        .o_track     (w_sel_track)
    );

    // shared draw unit
    rmss_draw u_draw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_draw_req),
        .o_rsp   (w_rsp)
    );

    // fields of the latched track
    assign w_lo      = r_cur[rmss_pkg::FIELD_W-1:0] & DELAY_MASK;
    assign w_hi      = r_cur[rmss_pkg::MAX_LSB +: rmss_pkg::FIELD_W] & DELAY_MASK;
    assign w_music   = r_cur[rmss_pkg::MUSIC_BIT];
    assign w_replace = r_cur[rmss_pkg::REPL_BIT];

    // drawn delay and countdown after the min
    assign w_d    = $signed({16'd0, w_rsp.value});
    assign w_newc = (w_d < r_count) ? w_d : r_count;

    // tick sequencer
    always_comb begin
        n_state    = r_state;
        n_sit      = r_sit;
        n_sounding = r_sounding;
        n_cur      = r_cur;
        n_playing  = r_playing;
        n_count    = r_count;
        n_reroll   = r_reroll;
        n_draw_req = r_draw_req;
        n_res_act  = r_res_act;
        n_res_sit  = r_res_sit;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_action = r_o_action;
        n_o_sit    = r_o_sit;
        n_draw_req.start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sit      = i_situation;
                    n_sounding = i_music_sounding;
                    n_cur      = w_sel_track;
                    n_res_act  = rmss_pkg::ACT_NONE;
                    n_res_sit  = rmss_pkg::SIT_NONE;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_playing != rmss_pkg::SIT_NONE) begin
                    if ((r_sit != r_playing) && w_music && w_replace) begin
                        n_playing = r_sit;
                        n_count   = rmss_pkg::COUNT_MAX;
                        n_res_act = rmss_pkg::ACT_REPLACE;
                        n_res_sit = r_sit;
                        n_state   = S_OUT;
                    end else if (r_sounding) begin
                        n_state = S_OUT;
                    end else begin
                        // song over: re-roll the countdown, or set it to the floor without music
                        n_playing = rmss_pkg::SIT_NONE;
                        if (w_music) begin
                            n_reroll         = 1'b1;
                            n_draw_req.start = 1'b1;
                            n_draw_req.lo    = w_lo;
                            n_draw_req.hi    = w_hi;
                            n_state          = S_WAIT;
                        end else begin
                            n_count = rmss_pkg::FLOOR_DELAY;
                            n_state = S_STEP;
                        end
                    end
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (!w_music) begin
                    if (r_count < rmss_pkg::FLOOR_DELAY) begin
                        n_count = rmss_pkg::FLOOR_DELAY;
                    end
                    n_state = S_OUT;
                end else begin
                    n_reroll         = 1'b0;
                    n_draw_req.start = 1'b1;
                    n_draw_req.lo    = w_lo;
                    n_draw_req.hi    = w_hi;
                    n_state          = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_rsp.done) begin
                    if (r_reroll) begin
                        n_count = w_d;
                        n_state = S_STEP;
                    end else begin
                        if (w_newc <= 32'sd0) begin
                            n_playing = r_sit;
                            n_count   = rmss_pkg::COUNT_MAX;
                            n_res_act = rmss_pkg::ACT_START;
                            n_res_sit = r_sit;
                        end else begin
                            n_count = w_newc - 32'sd1;
                        end
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                // hand over once the output register is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_action = r_res_act;
                    n_o_sit    = r_res_sit;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_playing        <= rmss_pkg::SIT_NONE;
            r_count          <= rmss_pkg::COUNT_MAX;
            r_reroll         <= 1'b0;
            r_draw_req.start <= 1'b0;
            r_o_valid        <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_playing        <= n_playing;
            r_count          <= n_count;
            r_reroll         <= n_reroll;
            r_draw_req.start <= n_draw_req.start;
            r_o_valid        <= n_o_valid;
        end
        r_sit          <= n_sit;
        r_sounding     <= n_sounding;
        r_cur          <= n_cur;
        r_draw_req.lo  <= n_draw_req.lo;
        r_draw_req.hi  <= n_draw_req.hi;
        r_res_act      <= n_res_act;
        r_res_sit      <= n_res_sit;
        r_o_action     <= n_o_action;
        r_o_sit        <= n_o_sit;
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_valid           = r_o_valid;
    assign o_action          = r_o_action;
    assign o_track_situation = r_o_sit;

    // a track in play always has the countdown parked at its maximum
    a_playing_parks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_playing != rmss_pkg::SIT_NONE) |-> (r_count == rmss_pkg::COUNT_MAX))
        else $error("countdown not parked while a track plays");

    // an accepted tick moves straight into evaluation
    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EVAL))
        else $error("accepted tick did not enter evaluation");

    // the draw unit only answers while the sequencer waits for it
    a_draw_answer_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WAIT))
        else $error("draw answer outside the wait state");

    // an empty action never names a situation
    a_none_has_no_sit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == rmss_pkg::ACT_NONE)) |->
        (o_track_situation == rmss_pkg::SIT_NONE))
        else $error("situation given with an empty action");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// testbench for the randomised music start scheduler: predicted results per tick
`timescale 1ns / 100ps

module tb;

    localparam int        DELAY_W    = 16;
    localparam bit [31:0] DELAY_MASK = (32'd1 << DELAY_W) - 32'd1;

    // one result transaction: action and the situation whose track to play
    typedef struct packed {
        logic [1:0] action;
        logic [2:0] sit;
    } t_music_result;

    // predicted scheduler state and the results still owed by the block
    class t_music_start_predictor;
        bit [rmss_pkg::TRACK_W-1:0] track_reg [4];
        logic [2:0]                 playing;
        int                         countdown;
        bit [31:0]                  lcg;
        t_music_result              owed_results [$];
        int                         errors;

        function new();
            track_reg[rmss_pkg::REG_MENU[1:0]]       = rmss_pkg::RST_MENU;
            track_reg[rmss_pkg::REG_CREATIVE[1:0]]   = rmss_pkg::RST_CREATIVE;
            track_reg[rmss_pkg::REG_GAME[1:0]]       = rmss_pkg::RST_GAME;
            track_reg[rmss_pkg::REG_UNDERWATER[1:0]] = rmss_pkg::RST_UNDERWATER;
            playing      = rmss_pkg::SIT_NONE;
            countdown    = rmss_pkg::COUNT_MAX;
            lcg          = '0;
            errors       = 0;
        endfunction

        task report(string what);
            if (errors < 100)
                $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function int pending();
            return owed_results.size();
        endfunction

        // writes past the last track register are dropped
        function void write_track(logic [2:0] idx, bit [rmss_pkg::TRACK_W-1:0] value);
            if (idx < rmss_pkg::REG_COUNT)
                track_reg[idx[1:0]] = value;
        endfunction

        // random delay between min and max, generator untouched on an empty span
        function int roll_delay(bit [rmss_pkg::TRACK_W-1:0] t);
            int          lo;
            int          hi;
            int unsigned span;
            lo = t[rmss_pkg::FIELD_W-1:0] & DELAY_MASK;
            hi = t[rmss_pkg::MAX_LSB +: rmss_pkg::FIELD_W] & DELAY_MASK;
            if (hi <= lo)
                return lo;
            lcg  = lcg * rmss_pkg::LCG_MUL + rmss_pkg::LCG_ADD;
            span = hi - lo + 1;
            return lo + int'((lcg >> rmss_pkg::DRAW_SHIFT) % span);
        endfunction

        // advance the state by one accepted tick and queue its result
        function void accept_tick(logic [2:0] sit, logic sounding);
            bit [rmss_pkg::TRACK_W-1:0] cur;
            t_music_result              res;
            int                         fresh;
            cur = '0;
            if (sit >= rmss_pkg::SIT_MENU && sit <= rmss_pkg::SIT_UNDERWATER)
                cur = track_reg[sit - 3'd1];
            res.action = rmss_pkg::ACT_NONE;
            res.sit    = rmss_pkg::SIT_NONE;
            if (playing != rmss_pkg::SIT_NONE && sit != playing &&
                cur[rmss_pkg::MUSIC_BIT] && cur[rmss_pkg::REPL_BIT]) begin
                playing    = sit;
                countdown  = rmss_pkg::COUNT_MAX;
                res.action = rmss_pkg::ACT_REPLACE;
                res.sit    = sit;
            end else if (playing != rmss_pkg::SIT_NONE && sounding) begin
                // song still audible: nothing to do
            end else begin
                // song over: clear and re-roll, then carry on within the tick
                if (playing != rmss_pkg::SIT_NONE) begin
                    playing   = rmss_pkg::SIT_NONE;
                    countdown = cur[rmss_pkg::MUSIC_BIT] ? roll_delay(cur)
                                                         : rmss_pkg::FLOOR_DELAY;
                end
                if (!cur[rmss_pkg::MUSIC_BIT]) begin
                    if (countdown < rmss_pkg::FLOOR_DELAY)
                        countdown = rmss_pkg::FLOOR_DELAY;
                end else begin
                    fresh = roll_delay(cur);
                    if (fresh < countdown)
                        countdown = fresh;
                    if (countdown <= 0) begin
                        playing    = sit;
                        countdown  = rmss_pkg::COUNT_MAX;
                        res.action = rmss_pkg::ACT_START;
                        res.sit    = sit;
                    end else begin
                        countdown = countdown - 1;
                    end
                end
            end
            owed_results.push_back(res);
        endfunction

        // compare one result transaction with the oldest prediction
        task check_result(logic [1:0] action, logic [2:0] sit);
            t_music_result want;
            if (owed_results.size() == 0) begin
                report($sformatf("result action %0d situation %0d with no tick waiting",
                                 action, sit));
            end else begin
                want = owed_results.pop_front();
                if (action !== want.action)
                    report($sformatf("action %0d, predicted %0d", action, want.action));
                if (sit !== want.sit)
                    report($sformatf("track situation %0d, predicted %0d", sit, want.sit));
            end
        endtask
    endclass

    logic                             i_clk            = 1'b0;
    logic                             i_rst_n          = 1'b0;
    logic                             i_valid          = 1'b0;
    logic                             o_ready;
    logic [2:0]                       i_situation      = rmss_pkg::SIT_NONE;
    logic                             i_music_sounding = 1'b0;
    logic                             o_valid;
    logic                             i_ready          = 1'b0;
    logic [1:0]                       o_action;
    logic [2:0]                       o_track_situation;
    logic                             i_cfg_valid      = 1'b0;
    logic                             o_cfg_ready;
    logic [rmss_pkg::CFG_INDEX_W-1:0] i_cfg_index      = rmss_pkg::REG_MENU;
    logic [rmss_pkg::TRACK_W-1:0]     i_cfg_data       = '0;

    t_music_start_predictor tracker;
    int                     tx_idle_pct      = 0;
    int                     rx_stall_pct     = 0;
    logic [2:0]             cur_sit          = rmss_pkg::SIT_MENU;

    // directed ticks after the directed track load: {situation, sounding}
    localparam logic [3:0] DIRECTED [20] = '{
        {rmss_pkg::SIT_MENU, 1'b0}, {rmss_pkg::SIT_MENU, 1'b0},
        {rmss_pkg::SIT_MENU, 1'b0}, {rmss_pkg::SIT_MENU, 1'b0},
        {rmss_pkg::SIT_MENU, 1'b0}, {rmss_pkg::SIT_MENU, 1'b1},
        {rmss_pkg::SIT_CREATIVE, 1'b1}, {rmss_pkg::SIT_GAME, 1'b1},
        {3'd5, 1'b1}, {rmss_pkg::SIT_GAME, 1'b0}, {rmss_pkg::SIT_NONE, 1'b0}, {3'd6, 1'b0},
        {3'd7, 1'b1}, {rmss_pkg::SIT_CREATIVE, 1'b0},
        {rmss_pkg::SIT_CREATIVE, 1'b0}, {rmss_pkg::SIT_CREATIVE, 1'b0},
        {rmss_pkg::SIT_UNDERWATER, 1'b1}, {rmss_pkg::SIT_MENU, 1'b1},
        {rmss_pkg::SIT_MENU, 1'b0}, {rmss_pkg::SIT_UNDERWATER, 1'b0}
    };

    randomized_music_start_scheduler_top #(
        .DELAY_WIDTH(DELAY_W)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_situation      (i_situation),
        .i_music_sounding (i_music_sounding),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_action         (o_action),
        .o_track_situation(o_track_situation),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_result(o_action, o_track_situation);
    end

    // one tick transaction; valid is left high for the caller to reuse or drop
    task automatic send_tick(input logic [2:0] sit, input logic sounding);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_situation      <= sit;
        i_music_sounding <= sounding;
        do @(posedge i_clk); while (!o_ready);
        tracker.accept_tick(sit, sounding);
        @(negedge i_clk);
    endtask

    // hold off ticks until every owed result has come back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic write_track(input logic [2:0] idx,
                               input logic [rmss_pkg::TRACK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_track(idx, value);
        @(negedge i_clk);
    endtask

    // all four tracks plus one write to an unused index
    task automatic load_tracks(input logic [rmss_pkg::TRACK_W-1:0] menu,
                               input logic [rmss_pkg::TRACK_W-1:0] creative,
                               input logic [rmss_pkg::TRACK_W-1:0] game,
                               input logic [rmss_pkg::TRACK_W-1:0] water);
        write_track(rmss_pkg::REG_MENU, menu);
        write_track(rmss_pkg::REG_CREATIVE, creative);
        write_track(rmss_pkg::REG_GAME, game);
        write_track(rmss_pkg::REG_UNDERWATER, water);
        write_track(3'($urandom_range(7, 4)), rmss_pkg::TRACK_W'({$urandom, $urandom}));
        i_cfg_valid <= 1'b0;
    endtask

    // mostly short delays so that songs start often, now and then wide ranges
    function automatic logic [rmss_pkg::TRACK_W-1:0] random_track();
        logic [rmss_pkg::FIELD_W-1:0] lo;
        logic [rmss_pkg::FIELD_W-1:0] hi;
        logic                         music;
        logic                         repl;
        case ($urandom_range(9))
            0: begin
                lo = rmss_pkg::FIELD_W'($urandom);
                hi = rmss_pkg::FIELD_W'($urandom);
            end
            1: begin
                lo = rmss_pkg::FIELD_W'($urandom_range(8));
                hi = lo;
            end
            2: begin
                lo = rmss_pkg::FIELD_W'($urandom_range(9, 3));
                hi = rmss_pkg::FIELD_W'($urandom_range(2));
            end
            default: begin
                lo = rmss_pkg::FIELD_W'($urandom_range(6));
                hi = lo + rmss_pkg::FIELD_W'($urandom_range(10));
            end
        endcase
        music = ($urandom_range(99) < 85);
        repl  = 1'($urandom);
        return {music, repl, hi, lo};
    endfunction

    function automatic logic [2:0] pick_situation();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return 3'($urandom_range(4, 1));
        if (r < 90)
            return rmss_pkg::SIT_NONE;
        return 3'($urandom_range(7, 5));
    endfunction

    // situations that persist, songs that sound for a while, some noise
    task automatic random_ticks(input int count);
        logic [2:0] sit;
        logic       sounding;
        repeat (count) begin
            if ($urandom_range(99) == 0)
                wait_results_drained();
            if ($urandom_range(99) < 12)
                cur_sit = pick_situation();
            if ($urandom_range(99) < 6) begin
                sit      = 3'($urandom);
                sounding = 1'($urandom);
            end else begin
                sit      = cur_sit;
                sounding = (tracker.playing != rmss_pkg::SIT_NONE) ? ($urandom_range(99) < 85)
                                                                   : 1'($urandom);
            end
            send_tick(sit, sounding);
        end
    endtask

    // stimulus
    initial begin
        tracker = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // a few ticks on the reset track settings
        send_tick(rmss_pkg::SIT_MENU, 1'b0);
        send_tick(rmss_pkg::SIT_NONE, 1'b0);
        send_tick(rmss_pkg::SIT_GAME, 1'b0);
        wait_results_drained();
        repeat (8) @(negedge i_clk);

        // short spans, equal bounds, max under min, widest span
        load_tracks({1'b1, 1'b1, 16'd3, 16'd0},
                    {1'b1, 1'b1, 16'd2, 16'd2},
                    {1'b1, 1'b0, 16'd1, 16'd5},
                    {1'b1, 1'b1, 16'hFFFF, 16'd0});
        foreach (DIRECTED[i])
            send_tick(DIRECTED[i][3:1], DIRECTED[i][0]);

        // random phases over track settings and idling patterns
        for (int p = 0; p < 8; p++) begin
            wait_results_drained();
            repeat (8) @(negedge i_clk);
            if (p == 0)
                load_tracks('0, '0, '0, '0);
            else if (p == 1)
                load_tracks('1, '1, '1, '1);
            else
                load_tracks(random_track(), random_track(), random_track(), random_track());
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            random_ticks((p < 2) ? 40 : 260);
        end

        wait_results_drained();
        repeat (70) @(negedge i_clk);
        if (tracker.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // run time limit
    initial begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

@@ randomized_music_start_scheduler_top.f @@
src/rmss_pkg.sv
src/rmss_track_regs.sv
src/rmss_draw.sv
src/randomized_music_start_scheduler_top.sv
dv/tb.sv
